>>> hw/rtl/sssa_pkg.sv
package sssa_pkg;

  // configuration register widths and reset values
  localparam int POLL_INTERVAL_W = 16;
  localparam int SET_DELAY_W     = 24;
  localparam int POLLS_PER_SET_W = 5;
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [POLL_INTERVAL_W-1:0] POLL_INTERVAL_RST = 16'd2000;
  localparam logic [SET_DELAY_W-1:0]     SET_DELAY_RST     = 24'd60000;
  localparam logic [POLLS_PER_SET_W-1:0] POLLS_PER_SET_RST = 5'd5;

  // default largest set size
  localparam int MAX_POLLS_DEF = 16;

  // input item fields
  localparam int NOW_W      = 32;
  localparam int TEMP_W     = 11;
  localparam int HUMID_W    = 10;
  localparam int IN_NOW_LSB   = 0;
  localparam int IN_OK_BIT    = IN_NOW_LSB + NOW_W;
  localparam int IN_TEMP_LSB  = IN_OK_BIT + 1;
  localparam int IN_HUMID_LSB = IN_TEMP_LSB + TEMP_W;
  localparam int IN_TDATA_W   = 56;

  // result item fields
  localparam int OUT_TAKEN_BIT = 0;
  localparam int OUT_DISC_BIT  = 1;
  localparam int OUT_READY_BIT = 2;
  localparam int OUT_TEMP_LSB  = 3;
  localparam int OUT_HUMID_LSB = OUT_TEMP_LSB + TEMP_W;
  localparam int OUT_TDATA_W   = 24;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_SET_DELAY     = 2'd1,
    REG_POLLS_PER_SET = 2'd2
  } cfg_reg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_run;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/sensor_sample_set_averager.sv
// Sensor sample set averager. Each input transfer is one poll opportunity carrying a
// millisecond timestamp, a read-ok flag and a temperature and humidity reading in tenths;
// each one yields exactly one output transfer. A poll is taken when both the poll interval
// since the last taken poll and the set delay since the last finished set have passed
// (wrapping 32-bit differences). After polls_per_set taken polls (0 acts as 1, values above
// MAX_POLLS act as MAX_POLLS) the good readings are averaged with floor rounding and the
// averages are held on the output until the next set; a set in which every poll failed is
// dropped. An item that does not finish an averaged set passes capture, evaluate and output
// load, the load waiting while the output register is full. An item that finishes an
// averaged set also passes, between evaluate and output load, the restoring divider that
// produces one quotient bit per cycle for both averages at once, W = 11 + clog2(MAX_POLLS)
// quotient bits in all. No new item is taken until the last one is loaded to the output;
// the output is registered, so a new item is accepted while the previous result waits.
// Configuration writes are applied at once and are meant for idle periods.
module sensor_sample_set_averager #(
  parameter int MAX_POLLS = sssa_pkg::MAX_POLLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [sssa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sssa_pkg::CFG_DATA_W-1:0]  cfg_data,
  // poll opportunities
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // now_ms[31:0], read_ok[32], temp_tenths[43:33], humid_tenths[53:44], zero pad
  input  logic [sssa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // poll_taken[0], set_discarded[1], set_ready[2], avg_temp_tenths[13:3],
  // avg_humid_tenths[23:14]
  output logic [sssa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  sssa_pkg::cmd_t    cmd;
  sssa_pkg::status_t status;

  // sequencing
  sssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // gates, sums and divider
  sssa_dp #(
    .MAX_POLLS (MAX_POLLS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (s_axis_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata)
  );

endmodule

>>> hw/rtl/sssa_ctrl.sv
module sssa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sssa_pkg::status_t status,
  output sssa_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.need_div ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (status.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/sssa_dp.sv
module sssa_dp #(
  parameter int MAX_POLLS = sssa_pkg::MAX_POLLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sssa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sssa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [sssa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  sssa_pkg::cmd_t                   cmd,
  output sssa_pkg::status_t                status,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sssa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int CNT_W   = $clog2(MAX_POLLS + 1);
  localparam int TSUM_W  = sssa_pkg::TEMP_W + $clog2(MAX_POLLS);
  localparam int HSUM_W  = sssa_pkg::HUMID_W + $clog2(MAX_POLLS);
  localparam int DIV_W   = TSUM_W;
  localparam int STEP_W  = $clog2(DIV_W + 1);
  localparam int CMP_W   = (CNT_W > sssa_pkg::POLLS_PER_SET_W) ? CNT_W
                                                               : sssa_pkg::POLLS_PER_SET_W;
  localparam int NOW_W   = sssa_pkg::NOW_W;
  localparam int TEMP_W  = sssa_pkg::TEMP_W;
  localparam int HUMID_W = sssa_pkg::HUMID_W;

  // configuration registers
  logic [sssa_pkg::POLL_INTERVAL_W-1:0] poll_interval;
  logic [sssa_pkg::SET_DELAY_W-1:0]     set_delay;
  logic [sssa_pkg::POLLS_PER_SET_W-1:0] polls_per_set;

  // captured input item
  logic [NOW_W-1:0]          cap_now;
  logic                      cap_ok;
  logic signed [TEMP_W-1:0]  cap_temp;
  logic [HUMID_W-1:0]        cap_humid;

  // set state
  logic [NOW_W-1:0]          last_poll_time;
  logic [NOW_W-1:0]          last_set_time;
  logic signed [TSUM_W-1:0]  temp_sum;
  logic [HSUM_W-1:0]         humid_sum;
  logic [CNT_W-1:0]          poll_count;
  logic [CNT_W-1:0]          fail_count;
  logic [TEMP_W-1:0]         held_temp;
  logic [HUMID_W-1:0]        held_humid;

  // result flags of the current item
  logic                      flag_taken;
  logic                      flag_disc;
  logic                      flag_ready;

  // divider registers
  logic [DIV_W-1:0]          quo_t;
  logic [DIV_W-1:0]          quo_h;
  logic [CNT_W-1:0]          rem_t;
  logic [CNT_W-1:0]          rem_h;
  logic [CNT_W-1:0]          divisor;
  logic                      div_neg;
  logic [STEP_W-1:0]         div_steps;

  // evaluation signals
  logic [CMP_W-1:0]          pps_ext;
  logic [CMP_W-1:0]          target_ext;
  logic [CNT_W-1:0]          target;
  logic [NOW_W-1:0]          dt_poll;
  logic [NOW_W-1:0]          dt_set;
  logic                      gate;
  logic [CNT_W-1:0]          pc_inc;
  logic [CNT_W-1:0]          fc_inc;
  logic                      disc;
  logic                      finish;
  logic [CNT_W-1:0]          good;
  logic signed [TSUM_W-1:0]  tsum_new;
  logic [HSUM_W-1:0]         hsum_new;
  logic signed [TSUM_W-1:0]  tsum_neg;

  // divider step signals
  logic [CNT_W:0]            sh_t;
  logic [CNT_W:0]            sh_h;
  logic                      bit_t;
  logic                      bit_h;
  logic [DIV_W-1:0]          q_adj;
  logic [DIV_W-1:0]          t_res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_interval <= sssa_pkg::POLL_INTERVAL_RST;
      set_delay     <= sssa_pkg::SET_DELAY_RST;
      polls_per_set <= sssa_pkg::POLLS_PER_SET_RST;
    end else if (cfg_we) begin
      case (sssa_pkg::cfg_reg_t'(cfg_index))
        sssa_pkg::REG_POLL_INTERVAL:
          poll_interval <= cfg_data[sssa_pkg::POLL_INTERVAL_W-1:0];
        sssa_pkg::REG_SET_DELAY:
          set_delay <= cfg_data[sssa_pkg::SET_DELAY_W-1:0];
        sssa_pkg::REG_POLLS_PER_SET:
          polls_per_set <= cfg_data[sssa_pkg::POLLS_PER_SET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cap_now   <= in_tdata[sssa_pkg::IN_NOW_LSB +: NOW_W];
      cap_ok    <= in_tdata[sssa_pkg::IN_OK_BIT];
      cap_temp  <= in_tdata[sssa_pkg::IN_TEMP_LSB +: TEMP_W];
      cap_humid <= in_tdata[sssa_pkg::IN_HUMID_LSB +: HUMID_W];
    end
  end

  // set size clamped to one through the largest set
  always_comb begin
    pps_ext = CMP_W'(polls_per_set);
    if (pps_ext == '0) begin
      target_ext = CMP_W'(1);
    end else if (pps_ext > CMP_W'(MAX_POLLS)) begin
      target_ext = CMP_W'(MAX_POLLS);
    end else begin
      target_ext = pps_ext;
    end
    target = target_ext[CNT_W-1:0];
  end

  // time gates and set bookkeeping
  always_comb begin
    dt_poll  = cap_now - last_poll_time;
    dt_set   = cap_now - last_set_time;
    gate     = (dt_poll >= NOW_W'(poll_interval)) && (dt_set >= NOW_W'(set_delay));
    pc_inc   = poll_count + CNT_W'(1);
    fc_inc   = fail_count + CNT_W'(!cap_ok);
    disc     = !cap_ok && (fc_inc >= target);
    finish   = !disc && (pc_inc >= target);
    good     = pc_inc - fc_inc;
    tsum_new = cap_ok ? (temp_sum + TSUM_W'(cap_temp)) : temp_sum;
    hsum_new = cap_ok ? (humid_sum + HSUM_W'(cap_humid)) : humid_sum;
    tsum_neg = -tsum_new;
  end

  // restoring divider step, one quotient bit per lane
  always_comb begin
    sh_t  = {rem_t, quo_t[DIV_W-1]};
    sh_h  = {rem_h, quo_h[DIV_W-1]};
    bit_t = (sh_t >= {1'b0, divisor});
    bit_h = (sh_h >= {1'b0, divisor});
    q_adj = quo_t + DIV_W'(rem_t != '0);
    t_res = div_neg ? (DIV_W'(0) - q_adj) : quo_t;
  end

  assign status.need_div = gate && finish && (good != '0);
  assign status.div_done = (div_steps == STEP_W'(DIV_W));
  assign status.out_free = !out_tvalid || out_tready;

  // set state update on evaluation
  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time <= '0;
      last_set_time  <= '0;
      temp_sum       <= '0;
      humid_sum      <= '0;
      poll_count     <= '0;
      fail_count     <= '0;
    end else if (cmd.eval && gate) begin
      last_poll_time <= cap_now;
      if (finish) begin
        last_set_time <= cap_now;
      end
      if (disc || finish) begin
        temp_sum   <= '0;
        humid_sum  <= '0;
        poll_count <= '0;
        fail_count <= '0;
      end else begin
        temp_sum   <= tsum_new;
        humid_sum  <= hsum_new;
        poll_count <= pc_inc;
        fail_count <= fc_inc;
      end
    end
  end

  // result flags
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      flag_taken <= gate;
      flag_disc  <= gate && disc;
      flag_ready <= status.need_div;
    end
  end

  // divider load and iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      div_steps <= '0;
    end else if (cmd.eval && status.need_div) begin
      div_steps <= '0;
    end else if (cmd.div_run && !status.div_done) begin
      div_steps <= div_steps + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && status.need_div) begin
      div_neg <= tsum_new[TSUM_W-1];
      quo_t   <= DIV_W'(tsum_new[TSUM_W-1] ? tsum_neg : tsum_new);
      quo_h   <= DIV_W'(hsum_new);
      rem_t   <= '0;
      rem_h   <= '0;
      divisor <= good;
    end else if (cmd.div_run && !status.div_done) begin
      quo_t <= {quo_t[DIV_W-2:0], bit_t};
      quo_h <= {quo_h[DIV_W-2:0], bit_h};
      rem_t <= bit_t ? CNT_W'(sh_t - {1'b0, divisor}) : CNT_W'(sh_t);
      rem_h <= bit_h ? CNT_W'(sh_h - {1'b0, divisor}) : CNT_W'(sh_h);
    end
  end

  // held averages, floor toward minus infinity
  always_ff @(posedge clk) begin
    if (rst) begin
      held_temp  <= '0;
      held_humid <= '0;
    end else if (cmd.div_run && status.div_done) begin
      held_temp  <= t_res[TEMP_W-1:0];
      held_humid <= quo_h[HUMID_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= {held_humid, held_temp, flag_ready, flag_disc, flag_taken};
    end
  end

  // a new average is only produced by a taken poll
  assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> (!out_tdata[sssa_pkg::OUT_READY_BIT] || out_tdata[sssa_pkg::OUT_TAKEN_BIT]))
    else $error("set_ready without poll_taken");

  // a set is either averaged or discarded, never both
  assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> !(out_tdata[sssa_pkg::OUT_READY_BIT] && out_tdata[sssa_pkg::OUT_DISC_BIT]))
    else $error("set both averaged and discarded");

  // counts stay within one set
  assert property (@(posedge clk) disable iff (rst)
    (fail_count <= poll_count) && (poll_count <= CNT_W'(MAX_POLLS)))
    else $error("poll or fail count out of range");

  // the divider step counter never passes DIV_W
  assert property (@(posedge clk) disable iff (rst)
    div_steps <= STEP_W'(DIV_W))
    else $error("divider step count overrun");

  // a divide is never started with a zero divisor
  assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && status.need_div) |=> (divisor != '0))
    else $error("divide by zero good polls");

endmodule
